/* sv/sfbd_pkg.sv */
// ----------------------------------------------------------------------------
// sfbd_pkg: shared types and constants of the spectral flux beat detector
// fixed-point widths, offset steps, register indexes and the control states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfbd_pkg;

	localparam int MAG_W  = 16;   // bin magnitude, Q2.14
	localparam int FLUX_W = 25;   // flux, medians, threshold, Q11.14
	localparam int OFF_W  = 16;   // threshold offset, Q2.14
	localparam int TIME_W = 32;   // millisecond time
	localparam int CFG_W  = 16;   // configuration data
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_DECAY = 1'd1;

	localparam logic [CFG_W-1:0] REFRACTORY_RESET = 16'd350;
	localparam logic [CFG_W-1:0] IDLE_DECAY_RESET = 16'd5000;

	localparam logic [FLUX_W-1:0] FLUX_MAX = 25'h1FFFFFF;

	localparam logic [OFF_W-1:0] OFF_RESET = 16'd9830;
	localparam logic [OFF_W-1:0] OFF_0P8   = 16'd13107;
	localparam logic [OFF_W-1:0] OFF_1P0   = 16'd16384;
	localparam logic [OFF_W-1:0] OFF_2P2   = 16'd36045;
	localparam logic [OFF_W-1:0] OFF_2P4   = 16'd39322;
	localparam logic [OFF_W-1:0] OFF_DECAY = 16'd6554;

	// beat median breakpoints 1, 2, 4 and 6 in Q11.14
	localparam logic [FLUX_W-1:0] MED_1 = 25'd16384;
	localparam logic [FLUX_W-1:0] MED_2 = 25'd32768;
	localparam logic [FLUX_W-1:0] MED_4 = 25'd65536;
	localparam logic [FLUX_W-1:0] MED_6 = 25'd98304;

	typedef enum logic [5:0] {
		ST_RUN  = 6'b000001,
		ST_FMED = 6'b000010,
		ST_BMED = 6'b000100,
		ST_OFF  = 6'b001000,
		ST_THR  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

endpackage

/* sv/sfbd_ram.sv */
// ----------------------------------------------------------------------------
// sfbd_ram: generic single-port-write, single-port-read synchronous ram
// read data registered, old data on a same-address write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfbd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* sv/spectral_flux_beat_detector_unit.sv */
// ----------------------------------------------------------------------------
// spectral_flux_beat_detector_unit: spectral flux onset and beat detection
// throughput: one bin request per cycle; after a frame's last bin the input
//   stalls through the flux and beat median rank passes and the offset,
//   threshold and finish steps, longer while the previous result still waits
//   in the output register
// reset: no clearing pass; a fill count makes unwritten bins read as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectral_flux_beat_detector_unit #(
	parameter int BINS        = 512,
	parameter int FLUX_WINDOW = 9,
	parameter int BEAT_WINDOW = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfbd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sfbd_pkg::CFG_W-1:0]     cfg_data,
	// bin input channel
	input  logic                           bin_valid,
	output logic                           bin_ready,
	input  logic [sfbd_pkg::MAG_W-1:0]     bin_magnitude,
	input  logic                           bin_last,
	input  logic [sfbd_pkg::TIME_W-1:0]    time_ms,
	// frame result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic                           beat,
	output logic [sfbd_pkg::FLUX_W-1:0]    flux,
	output logic [sfbd_pkg::FLUX_W-1:0]    threshold,
	output logic [sfbd_pkg::TIME_W-1:0]    frame_time_ms
);

	localparam int ADDR_W = $clog2(BINS);
	localparam int FILL_W = $clog2(BINS + 1);
	localparam int FCNT_W = $clog2(FLUX_WINDOW + 1);
	localparam int BCNT_W = $clog2(BEAT_WINDOW + 1);
	localparam int IDX_W  = (FCNT_W > BCNT_W) ? FCNT_W : BCNT_W;

	localparam int MAG_W  = sfbd_pkg::MAG_W;
	localparam int FLUX_W = sfbd_pkg::FLUX_W;
	localparam int OFF_W  = sfbd_pkg::OFF_W;
	localparam int TIME_W = sfbd_pkg::TIME_W;
	localparam int CFG_W  = sfbd_pkg::CFG_W;

	// ------------------------------------------------------------------------
	// configuration registers, always writable
	// ------------------------------------------------------------------------
	logic [CFG_W-1:0] refractory_q;
	logic [CFG_W-1:0] idle_decay_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refractory_q <= sfbd_pkg::REFRACTORY_RESET;
			idle_decay_q <= sfbd_pkg::IDLE_DECAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sfbd_pkg::REG_REFRACTORY: refractory_q <= cfg_data;
				sfbd_pkg::REG_IDLE_DECAY: idle_decay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// state and control
	// ------------------------------------------------------------------------
	sfbd_pkg::state_t state_q;

	logic              bin_acc;       // bin request taken this cycle
	logic [ADDR_W-1:0] pos_q;         // bin position within the frame

	// stage 1: ram data arrives, difference, accumulate, write back
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [MAG_W-1:0]  mag_s1;
	logic              last_s1;
	logic [TIME_W-1:0] time_s1;

	// last write into the bin store, for same-address forwarding
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	logic [MAG_W-1:0]  lw_data_q;

	// entries at or above the fill mark were never written and read as zero
	logic [FILL_W-1:0] fill_q;

	logic [MAG_W-1:0]  ram_rd;
	logic [MAG_W-1:0]  prev_mag;
	logic [MAG_W-1:0]  diff;
	logic [FLUX_W:0]   acc_sum;
	logic [FLUX_W-1:0] acc_sat;
	logic [FLUX_W-1:0] acc_q;

	// frame-end working registers
	logic [FLUX_W-1:0] fflux_q;
	logic [TIME_W-1:0] ftime_q;
	logic [FLUX_W-1:0] fmed_q;
	logic [FLUX_W-1:0] bmed_q;
	logic [OFF_W-1:0]  offset_q;
	logic [TIME_W-1:0] last_event_q;
	logic [FLUX_W-1:0] thr_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [IDX_W-1:0]  idx_q;
	logic [FLUX_W-1:0] found_q;

	// small histories kept in a shift line, oldest at entry 0
	logic [FLUX_W-1:0] fhist_q [FLUX_WINDOW];
	logic [FCNT_W-1:0] fcnt_q;
	logic [FLUX_W-1:0] bhist_q [BEAT_WINDOW];
	logic [BCNT_W-1:0] bcnt_q;

	// output register
	logic              res_valid_q;
	logic              beat_q;
	logic [FLUX_W-1:0] flux_q;
	logic [FLUX_W-1:0] thr_out_q;
	logic [TIME_W-1:0] time_out_q;

	// bins flow only in the run state, and never past a frame's last bin
	assign bin_ready = (state_q == sfbd_pkg::ST_RUN) && !(valid_s1 && last_s1);
	assign bin_acc   = bin_valid && bin_ready;

	// ------------------------------------------------------------------------
	// previous-frame bin store
	// ------------------------------------------------------------------------
	sfbd_ram #(
		.WIDTH (MAG_W),
		.DEPTH (BINS)
	) u_prev_ram (
		.clk     (clk),
		.wr_en   (valid_s1),
		.wr_addr (addr_s1),
		.wr_data (mag_s1),
		.rd_en   (bin_acc),
		.rd_addr (pos_q),
		.rd_data (ram_rd)
	);

	// pick previous magnitude: forwarded, stored, or zero when never written
	always_comb begin
		if (lw_valid_q && (lw_addr_q == addr_s1)) begin
			prev_mag = lw_data_q;
		end else if (FILL_W'(addr_s1) < fill_q) begin
			prev_mag = ram_rd;
		end else begin
			prev_mag = '0;
		end
		diff    = (mag_s1 > prev_mag) ? (mag_s1 - prev_mag) : '0;
		acc_sum = {1'b0, acc_q} + (FLUX_W + 1)'(diff);
		acc_sat = acc_sum[FLUX_W] ? sfbd_pkg::FLUX_MAX : acc_sum[FLUX_W-1:0];
	end

	// ------------------------------------------------------------------------
	// median rank passes: one candidate per cycle, compared with all entries
	// the candidate whose stable rank equals count/2 is the upper median
	// ------------------------------------------------------------------------
	logic [FLUX_W-1:0] fcand;
	logic [FCNT_W-1:0] frank;
	logic              fmatch;
	logic              flast;
	logic [FLUX_W-1:0] fpick;
	logic [FLUX_W-1:0] bcand;
	logic [BCNT_W-1:0] brank;
	logic              bmatch;
	logic              blast;
	logic [FLUX_W-1:0] bpick;

	always_comb begin
		fcand = '0;
		for (int j = 0; j < FLUX_WINDOW; j++) begin
			if (IDX_W'(j) == idx_q) begin
				fcand = fhist_q[j];
			end
		end
		frank = '0;
		for (int j = 0; j < FLUX_WINDOW; j++) begin
			if ((FCNT_W'(j) < fcnt_q) && ((fhist_q[j] < fcand) ||
			    ((fhist_q[j] == fcand) && (IDX_W'(j) < idx_q)))) begin
				frank = frank + 1'b1;
			end
		end
		fmatch = (frank == (fcnt_q >> 1));
		flast  = (idx_q == IDX_W'(fcnt_q - 1'b1));
		fpick  = fmatch ? fcand : found_q;
	end

	always_comb begin
		bcand = '0;
		for (int j = 0; j < BEAT_WINDOW; j++) begin
			if (IDX_W'(j) == idx_q) begin
				bcand = bhist_q[j];
			end
		end
		brank = '0;
		for (int j = 0; j < BEAT_WINDOW; j++) begin
			if ((BCNT_W'(j) < bcnt_q) && ((bhist_q[j] < bcand) ||
			    ((bhist_q[j] == bcand) && (IDX_W'(j) < idx_q)))) begin
				brank = brank + 1'b1;
			end
		end
		bmatch = (brank == (bcnt_q >> 1));
		blast  = (idx_q == IDX_W'(bcnt_q - 1'b1));
		bpick  = bmatch ? bcand : found_q;
	end

	// ------------------------------------------------------------------------
	// offset step on the beat median, later matches win
	// ------------------------------------------------------------------------
	logic [OFF_W-1:0]  off_next;
	logic [FLUX_W:0]   thr_sum;
	logic              beat_now;
	logic              out_free;

	always_comb begin
		off_next = offset_q;
		if (bmed_q > sfbd_pkg::MED_1) begin
			off_next = sfbd_pkg::OFF_0P8;
		end
		if ((bmed_q > sfbd_pkg::MED_2) && (bmed_q < sfbd_pkg::MED_4)) begin
			off_next = sfbd_pkg::OFF_1P0;
		end
		if ((bmed_q > sfbd_pkg::MED_4) && (bmed_q < sfbd_pkg::MED_6)) begin
			off_next = sfbd_pkg::OFF_2P2;
		end
		if (bmed_q > sfbd_pkg::MED_6) begin
			off_next = sfbd_pkg::OFF_2P4;
		end
		thr_sum  = {1'b0, fmed_q} + (FLUX_W + 1)'(offset_q);
		// refractory check against the elapsed time since the last event
		beat_now = (fflux_q > thr_q) && (elapsed_q > TIME_W'(refractory_q));
		out_free = !res_valid_q || result_ready;
	end

	// ------------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sfbd_pkg::ST_RUN;
			pos_q        <= '0;
			valid_s1     <= 1'b0;
			lw_valid_q   <= 1'b0;
			fill_q       <= '0;
			acc_q        <= '0;
			fcnt_q       <= '0;
			bcnt_q       <= '0;
			fmed_q       <= '0;
			bmed_q       <= '0;
			offset_q     <= sfbd_pkg::OFF_RESET;
			last_event_q <= '0;
			idx_q        <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			valid_s1   <= bin_acc;
			lw_valid_q <= valid_s1;

			if (bin_acc) begin
				if (bin_last || (pos_q == ADDR_W'(BINS - 1))) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end

			// fill mark follows the highest bin written so far
			if (valid_s1 && (FILL_W'(addr_s1) >= fill_q)) begin
				fill_q <= FILL_W'(addr_s1) + 1'b1;
			end

			// result register loads at frame finish, empties when taken
			if ((state_q == sfbd_pkg::ST_FIN) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result_valid && result_ready) begin
				res_valid_q <= 1'b0;
			end

			unique case (state_q)
				sfbd_pkg::ST_RUN: begin
					if (valid_s1) begin
						if (last_s1) begin
							acc_q <= '0;
							idx_q <= '0;
							state_q <= (fcnt_q != '0) ? sfbd_pkg::ST_FMED
							                          : sfbd_pkg::ST_OFF;
						end else begin
							acc_q <= acc_sat;
						end
					end
				end
				sfbd_pkg::ST_FMED: begin
					if (flast) begin
						idx_q <= '0;
						if (fpick != '0) begin
							fmed_q <= fpick;
						end
						// beat median pass runs whatever the flux median was
						state_q <= (bcnt_q != '0) ? sfbd_pkg::ST_BMED
						                          : sfbd_pkg::ST_OFF;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				sfbd_pkg::ST_BMED: begin
					if (blast) begin
						idx_q <= '0;
						state_q <= sfbd_pkg::ST_OFF;
						if (bpick != '0) begin
							bmed_q <= bpick;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				sfbd_pkg::ST_OFF: begin
					offset_q <= off_next;
					if (fcnt_q != FCNT_W'(FLUX_WINDOW)) begin
						fcnt_q <= fcnt_q + 1'b1;
					end
					state_q <= sfbd_pkg::ST_THR;
				end
				sfbd_pkg::ST_THR: begin
					state_q <= sfbd_pkg::ST_FIN;
				end
				sfbd_pkg::ST_FIN: begin
					if (out_free) begin
						state_q <= sfbd_pkg::ST_RUN;
						if (beat_now) begin
							last_event_q <= ftime_q;
							if (bcnt_q != BCNT_W'(BEAT_WINDOW)) begin
								bcnt_q <= bcnt_q + 1'b1;
							end
						end else if (elapsed_q > TIME_W'(idle_decay_q)) begin
							// long idle gap lowers the offset
							last_event_q <= ftime_q;
							if (offset_q > sfbd_pkg::OFF_DECAY) begin
								offset_q <= offset_q - sfbd_pkg::OFF_DECAY;
							end
						end
					end
				end
				default: state_q <= sfbd_pkg::ST_RUN;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// payload registers, no reset
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (bin_acc) begin
			addr_s1 <= pos_q;
			mag_s1  <= bin_magnitude;
			last_s1 <= bin_last;
			time_s1 <= time_ms;
		end

		lw_addr_q <= addr_s1;
		lw_data_q <= mag_s1;

		unique case (state_q)
			sfbd_pkg::ST_RUN: begin
				found_q <= '0;
				if (valid_s1 && last_s1) begin
					fflux_q <= acc_sat;
					ftime_q <= time_s1;
				end
			end
			sfbd_pkg::ST_FMED: begin
				found_q <= flast ? '0 : fpick;
			end
			sfbd_pkg::ST_BMED: begin
				found_q <= bpick;
			end
			sfbd_pkg::ST_OFF: begin
				// frame flux enters the flux history, oldest dropped when full
				if (fcnt_q == FCNT_W'(FLUX_WINDOW)) begin
					for (int j = 0; j < FLUX_WINDOW - 1; j++) begin
						fhist_q[j] <= fhist_q[j+1];
					end
					fhist_q[FLUX_WINDOW-1] <= fflux_q;
				end else begin
					for (int j = 0; j < FLUX_WINDOW; j++) begin
						if (FCNT_W'(j) == fcnt_q) begin
							fhist_q[j] <= fflux_q;
						end
					end
				end
			end
			sfbd_pkg::ST_THR: begin
				thr_q     <= thr_sum[FLUX_W] ? sfbd_pkg::FLUX_MAX
				                             : thr_sum[FLUX_W-1:0];
				elapsed_q <= ftime_q - last_event_q;
			end
			sfbd_pkg::ST_FIN: begin
				if (out_free) begin
					beat_q     <= beat_now;
					flux_q     <= fflux_q;
					thr_out_q  <= thr_q;
					time_out_q <= ftime_q;
					if (beat_now) begin
						if (bcnt_q == BCNT_W'(BEAT_WINDOW)) begin
							for (int j = 0; j < BEAT_WINDOW - 1; j++) begin
								bhist_q[j] <= bhist_q[j+1];
							end
							bhist_q[BEAT_WINDOW-1] <= fflux_q;
						end else begin
							for (int j = 0; j < BEAT_WINDOW; j++) begin
								if (BCNT_W'(j) == bcnt_q) begin
									bhist_q[j] <= fflux_q;
								end
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign result_valid  = res_valid_q;
	assign beat          = beat_q;
	assign flux          = flux_q;
	assign threshold     = thr_out_q;
	assign frame_time_ms = time_out_q;

endmodule

/* tb/spectral_flux_beat_detector_unit_tb.sv */
// ----------------------------------------------------------------------------
// spectral_flux_beat_detector_unit_tb: self-checking bench for the beat detector
// streams spectrum frames through the bin channel, predicts every frame result
// in a scoreboard and checks the result channel field by field, under several
// register settings and idle patterns on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectral_flux_beat_detector_unit_tb;

	localparam int MAG_W     = sfbd_pkg::MAG_W;
	localparam int FLUX_W    = sfbd_pkg::FLUX_W;
	localparam int OFF_W     = sfbd_pkg::OFF_W;
	localparam int TIME_W    = sfbd_pkg::TIME_W;
	localparam int CFG_W     = sfbd_pkg::CFG_W;
	localparam int CFG_IDX_W = sfbd_pkg::CFG_IDX_W;

	localparam int BINS        = 512;
	localparam int FLUX_WINDOW = 9;
	localparam int BEAT_WINDOW = 4;

	localparam int SETTLE_CYCLES = 24;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASE_BINS    = 50;
	localparam int HOLD_CYCLES   = 300;

	// one expected frame result
	typedef struct packed {
		logic              beat;
		logic [FLUX_W-1:0] flux;
		logic [FLUX_W-1:0] thr;
		logic [TIME_W-1:0] stamp;
	} frame_result_t;

	// frame predictor and result store
	class beat_scoreboard;
		logic [MAG_W-1:0]  prev_mag [BINS];
		logic [FLUX_W-1:0] flux_acc;
		logic [FLUX_W-1:0] flux_hist [$];
		logic [FLUX_W-1:0] beat_hist [$];
		logic [FLUX_W-1:0] flux_med;
		logic [FLUX_W-1:0] beat_med;
		logic [OFF_W-1:0]  offset;
		logic [TIME_W-1:0] last_event;
		logic [CFG_W-1:0]  refractory;
		logic [CFG_W-1:0]  idle_decay;
		int unsigned       pos;
		frame_result_t     expected_frames [$];
		int unsigned       errors;

		function new();
			foreach (prev_mag[i]) prev_mag[i] = '0;
			flux_acc   = '0;
			flux_med   = '0;
			beat_med   = '0;
			offset     = sfbd_pkg::OFF_RESET;
			last_event = '0;
			refractory = sfbd_pkg::REFRACTORY_RESET;
			idle_decay = sfbd_pkg::IDLE_DECAY_RESET;
			pos        = 0;
			errors     = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == sfbd_pkg::REG_REFRACTORY) refractory = data;
			else if (idx == sfbd_pkg::REG_IDLE_DECAY) idle_decay = data;
		endfunction

		// sorted entry count/2
		function logic [FLUX_W-1:0] upper_median(logic [FLUX_W-1:0] vals [$]);
			logic [FLUX_W-1:0] s [16];
			logic [FLUX_W-1:0] v;
			int n;
			int j;
			n = vals.size();
			for (int i = 0; i < n; i++) s[i] = vals[i];
			for (int i = 1; i < n; i++) begin
				v = s[i];
				j = i;
				while (j > 0 && s[j-1] > v) begin
					s[j] = s[j-1];
					j--;
				end
				s[j] = v;
			end
			return s[n/2];
		endfunction

		function void note_bin(logic [MAG_W-1:0] mag, logic last,
				logic [TIME_W-1:0] stamp);
			logic [FLUX_W:0]   sum;
			logic [FLUX_W-1:0] cur;
			logic [FLUX_W-1:0] m;
			logic [FLUX_W-1:0] thr;
			logic [TIME_W-1:0] elapsed;
			logic              hit;
			frame_result_t     res;
			if (mag > prev_mag[pos]) begin
				sum = {1'b0, flux_acc} + {10'd0, mag - prev_mag[pos]};
				flux_acc = (sum > {1'b0, sfbd_pkg::FLUX_MAX}) ? sfbd_pkg::FLUX_MAX
				                                             : sum[FLUX_W-1:0];
			end
			prev_mag[pos] = mag;
			pos = (pos == BINS - 1) ? 0 : pos + 1;
			if (!last) return;

			cur = flux_acc;
			// medians only move to nonzero values
			if (flux_hist.size() > 0) begin
				m = upper_median(flux_hist);
				if (m != '0) flux_med = m;
				if (beat_hist.size() > 0) begin
					m = upper_median(beat_hist);
					if (m != '0) beat_med = m;
				end
			end
			flux_hist = {flux_hist, cur};
			if (flux_hist.size() > FLUX_WINDOW) void'(flux_hist.pop_front());

			if (beat_med > sfbd_pkg::MED_1) offset = sfbd_pkg::OFF_0P8;
			if (beat_med > sfbd_pkg::MED_2 && beat_med < sfbd_pkg::MED_4)
				offset = sfbd_pkg::OFF_1P0;
			if (beat_med > sfbd_pkg::MED_4 && beat_med < sfbd_pkg::MED_6)
				offset = sfbd_pkg::OFF_2P2;
			if (beat_med > sfbd_pkg::MED_6) offset = sfbd_pkg::OFF_2P4;

			sum = {10'd0, offset} + {1'b0, flux_med};
			thr = (sum > {1'b0, sfbd_pkg::FLUX_MAX}) ? sfbd_pkg::FLUX_MAX
			                                        : sum[FLUX_W-1:0];

			elapsed = stamp - last_event;
			hit = (cur > thr) && (elapsed > {16'd0, refractory});
			if (hit) begin
				beat_hist = {beat_hist, cur};
				if (beat_hist.size() > BEAT_WINDOW) void'(beat_hist.pop_front());
				last_event = stamp;
			end else if (elapsed > {16'd0, idle_decay}) begin
				if (offset > sfbd_pkg::OFF_DECAY) offset = offset - sfbd_pkg::OFF_DECAY;
				last_event = stamp;
			end

			flux_acc = '0;
			pos = 0;
			res.beat  = hit;
			res.flux  = cur;
			res.thr   = thr;
			res.stamp = stamp;
			expected_frames = {expected_frames, res};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, name, want, got);
				errors++;
			end
		endfunction

		function void check_frame(logic b, logic [FLUX_W-1:0] f, logic [FLUX_W-1:0] thr,
				logic [TIME_W-1:0] stamp);
			frame_result_t e;
			if (expected_frames.size() == 0) begin
				$display("%0t: result with no frame outstanding, %s %0d",
					$time, "expected none, actual flux", f);
				errors++;
				return;
			end
			e = expected_frames.pop_front();
			compare_field("beat", 32'(e.beat), 32'(b));
			compare_field("flux", 32'(e.flux), 32'(f));
			compare_field("threshold", 32'(e.thr), 32'(thr));
			compare_field("frame_time_ms", e.stamp, stamp);
		endfunction
	endclass

	// clock, reset and block inputs, all known from time zero
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = sfbd_pkg::REG_REFRACTORY;
	logic [CFG_W-1:0]     cfg_data  = '0;

	logic                 bin_valid     = 1'b0;
	logic                 bin_ready;
	logic [MAG_W-1:0]     bin_magnitude = '0;
	logic                 bin_last      = 1'b0;
	logic [TIME_W-1:0]    time_ms       = '0;

	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic                 beat;
	logic [FLUX_W-1:0]    flux;
	logic [FLUX_W-1:0]    threshold;
	logic [TIME_W-1:0]    frame_time_ms;

	beat_scoreboard sb;

	// idle rates in percent, set per phase by the stimulus
	int unsigned send_idle_pct = 10;
	int unsigned recv_idle_pct = 50;

	// one long receiver hold-off: asked for by the stimulus, counted by the receiver
	bit          hold_ask  = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;

	int unsigned       bin_count   = 0;
	logic [TIME_W-1:0] frame_clock = 32'h0000_0100;

	always #5 clk = ~clk;

	spectral_flux_beat_detector_unit #(
		.BINS        (BINS),
		.FLUX_WINDOW (FLUX_WINDOW),
		.BEAT_WINDOW (BEAT_WINDOW)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bin_valid     (bin_valid),
		.bin_ready     (bin_ready),
		.bin_magnitude (bin_magnitude),
		.bin_last      (bin_last),
		.time_ms       (time_ms),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.beat          (beat),
		.flux          (flux),
		.threshold     (threshold),
		.frame_time_ms (frame_time_ms)
	);

	// result side: check every accepted result, then pick ready for the next edge
	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.check_frame(beat, flux, threshold, frame_time_ms);
		if (hold_ask && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			// long stall so the block backs up into the bin channel
			hold_left--;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one bin request; valid stays high after acceptance unless the next one idles
	task automatic push_bin(logic [MAG_W-1:0] mag, logic last, logic [TIME_W-1:0] stamp);
		if ($urandom_range(99) < send_idle_pct) begin
			bin_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		bin_valid     <= 1'b1;
		bin_magnitude <= mag;
		bin_last      <= last;
		time_ms       <= stamp;
		do @(posedge clk); while (!bin_ready);
		sb.note_bin(mag, last, stamp);
		bin_count++;
	endtask

	// both registers back to back, valid held high across the pair
	task automatic write_regs(logic [CFG_W-1:0] refr, logic [CFG_W-1:0] idle);
		cfg_valid <= 1'b1;
		cfg_index <= sfbd_pkg::REG_REFRACTORY;
		cfg_data  <= refr;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(sfbd_pkg::REG_REFRACTORY, refr);
		cfg_index <= sfbd_pkg::REG_IDLE_DECAY;
		cfg_data  <= idle;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(sfbd_pkg::REG_IDLE_DECAY, idle);
		cfg_valid <= 1'b0;
	endtask

	// short random frame; time only matters on the last bin, the others carry noise
	task automatic random_frame();
		int unsigned      len;
		logic [MAG_W-1:0] amp;
		bit               silent;
		len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 12);
		case ($urandom_range(3))
			0: amp = 16'h00FF;
			1: amp = 16'h0FFF;
			2: amp = 16'h3FFF;
			default: amp = 16'hFFFF;
		endcase
		silent = ($urandom_range(9) == 0);
		case ($urandom_range(63))
			0: frame_clock = $urandom;
			1, 2, 3, 4: frame_clock = frame_clock + $urandom_range(70000);
			default: frame_clock = frame_clock + $urandom_range(400);
		endcase
		for (int k = 0; k < len; k++)
			push_bin(silent ? '0 : MAG_W'($urandom) & amp, k == len - 1,
				(k == len - 1) ? frame_clock : $urandom);
	endtask

	// wait for every outstanding result, plus the block's latency
	task automatic settle();
		while (sb.expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(logic [CFG_W-1:0] refr, logic [CFG_W-1:0] idle,
			int unsigned s_pct, int unsigned r_pct, bit squeeze);
		int unsigned start;
		settle();
		write_regs(refr, idle);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		start = bin_count;
		while (bin_count - start < PHASE_BINS) begin
			if (squeeze && bin_count - start > PHASE_BINS / 3) hold_ask = 1'b1;
			random_frame();
		end
		bin_valid <= 1'b0;
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under reset register values
		// first frame runs one bin past the store, so the position wraps and bin 0
		// is compared with its own value from earlier in the same frame
		for (int k = 0; k < BINS + 1; k++)
			push_bin((k == 0) ? 16'h1000 : ((k == BINS) ? 16'h3000 : 16'h0000),
				k == BINS, (k == BINS) ? 32'd1000 : $urandom);
		// single-bin frames fill the flux history
		push_bin(16'h0000, 1'b1, 32'd1100);
		push_bin(16'hFFFF, 1'b1, 32'd1200);
		push_bin(16'h0000, 1'b1, 32'd1300);
		// zero fluxes pull the history median to zero, which keeps the old median
		push_bin(16'h0000, 1'b1, 32'd1400);
		push_bin(16'h0000, 1'b1, 32'd1500);
		push_bin(16'hFFFF, 1'b1, 32'd1600);
		// long quiet gap lowers the offset
		push_bin(16'h0000, 1'b1, 32'd7000);
		// multi-bin frame with alternating bit patterns
		push_bin(16'h5555, 1'b0, $urandom);
		push_bin(16'hAAAA, 1'b0, $urandom);
		push_bin(16'h8001, 1'b1, 32'd7100);
		push_bin(16'hFFFF, 1'b1, 32'd7450);
		// frame time wraps past the top of the counter
		push_bin(16'h0000, 1'b1, 32'hFFFF_FFF0);
		push_bin(16'hFFFF, 1'b1, 32'h0000_0020);
		bin_valid <= 1'b0;

		// random phases: sender light / receiver heavy, then swapped, then none
		run_phase(16'd0,     16'd0,     10, 50, 1'b1);
		run_phase(16'hFFFF,  16'hFFFF,  10, 50, 1'b0);
		run_phase(16'd0,     16'hFFFF,  50, 10, 1'b0);
		run_phase(16'hFFFF,  16'd0,     50, 10, 1'b0);
		run_phase(CFG_W'($urandom), CFG_W'($urandom), 0, 0, 1'b0);
		run_phase(CFG_W'($urandom_range(500)), CFG_W'($urandom_range(3000)), 0, 0, 1'b0);

		// drain, then give a stray result time to show up
		while (sb.expected_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("spectral_flux_beat_detector_unit_tb OK");
		else
			$display("spectral_flux_beat_detector_unit_tb NOT OK");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#3000000;
		$display("spectral_flux_beat_detector_unit_tb NOT OK");
		$finish;
	end

endmodule
